FILE: hw/rtl/npcm_pkg.sv
// package for the nearest palette color mapper
// types, codes and constants shared by all npcm modules; no dependencies
package npcm_pkg;

    // palette defaults and field widths
    localparam int unsigned PALETTE_DEPTH_DEF = 256;
    localparam int unsigned SLOT_W            = 9;
    localparam int unsigned DENSE_W           = 9;
    localparam int unsigned DIST_W            = 18;
    localparam int unsigned SEEN_DEPTH        = 257;
    localparam int unsigned SEARCH_LIMIT      = 256;

    // reserved slot used when the palette is empty
    localparam logic [SLOT_W-1:0] DEFAULT_SLOT = 9'd256;

    // transaction opcodes
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_PIXEL = 1'b1
    } t_op;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_LOOKUP,
        ST_COMMIT,
        ST_EMIT
    } t_state;

    // input transaction
    typedef struct packed {
        t_op        op;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic [SLOT_W-1:0]  chosen_entry;
        logic [DENSE_W-1:0] dense_index;
        logic               first_use;
    } t_out_item;

    // one color, packed the same way as a palette word
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    // slot tag that travels with a palette read
    typedef struct packed {
        logic       valid;
        logic [7:0] slot;
    } t_dist_tag;

    // distance result for one slot
    typedef struct packed {
        logic              valid;
        logic [7:0]        slot;
        logic [DIST_W-1:0] sq_dist;
    } t_dist_out;

    // request into the first-use table
    typedef struct packed {
        logic              lookup;
        logic              commit;
        logic [SLOT_W-1:0] slot;
    } t_seen_req;

    // first-use table answer
    typedef struct packed {
        logic [DENSE_W-1:0] dense;
        logic               first;
    } t_seen_rsp;

endpackage

FILE: hw/rtl/npcm_palette_ram.sv
// palette memory: one write port, one registered read port
// depends on npcm_pkg for the color type
module npcm_palette_ram #(
    parameter int unsigned DEPTH = npcm_pkg::PALETTE_DEPTH_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  npcm_pkg::t_rgba       i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output npcm_pkg::t_rgba       o_rdata
);
    import npcm_pkg::*;

    t_rgba r_mem [DEPTH];
    t_rgba r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/npcm_dist_unit.sv
// shared squared-distance unit, two stages: channel squares, then sum
// depends on npcm_pkg for color, tag and result types
module npcm_dist_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  npcm_pkg::t_rgba       i_pixel,
    input  npcm_pkg::t_rgba       i_entry,
    input  npcm_pkg::t_dist_tag   i_tag,
    output npcm_pkg::t_dist_out   o_result,
    output logic                  o_busy
);
    import npcm_pkg::*;

    // square of the absolute difference of two channels
    function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

    logic              r_s1_valid;
    logic [7:0]        r_s1_slot;
    logic [15:0]       r_sq_r;
    logic [15:0]       r_sq_g;
    logic [15:0]       r_sq_b;
    logic [15:0]       r_sq_a;
    logic              r_s2_valid;
    logic [7:0]        r_s2_slot;
    logic [DIST_W-1:0] r_sum;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_tag.valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // stage 1: per-channel squares
    always_ff @(posedge i_clk) begin
        r_s1_slot <= i_tag.slot;
        r_sq_r    <= chan_sq(i_pixel.red,   i_entry.red);
        r_sq_g    <= chan_sq(i_pixel.green, i_entry.green);
        r_sq_b    <= chan_sq(i_pixel.blue,  i_entry.blue);
        r_sq_a    <= chan_sq(i_pixel.alpha, i_entry.alpha);
    end

    // stage 2: sum of the four squares
    always_ff @(posedge i_clk) begin
        r_s2_slot <= r_s1_slot;
        r_sum     <= DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b) + DIST_W'(r_sq_a);
    end

    assign o_result.valid   = r_s2_valid;
    assign o_result.slot    = r_s2_slot;
    assign o_result.sq_dist = r_sum;
    assign o_busy           = r_s1_valid | r_s2_valid;

endmodule

FILE: hw/rtl/npcm_seen_table.sv
// first-use table: valid bit and dense index per slot, plus the next index
// depends on npcm_pkg for request and response types
module npcm_seen_table (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  npcm_pkg::t_seen_req   i_req,
    output npcm_pkg::t_seen_rsp   o_rsp
);
    import npcm_pkg::*;

    logic               r_valid [SEEN_DEPTH];
    logic [DENSE_W-1:0] r_mem   [SEEN_DEPTH];
    logic               r_hit;
    logic [DENSE_W-1:0] r_rd_dense;
    logic [SLOT_W-1:0]  r_slot;
    logic [DENSE_W-1:0] r_next_dense;
    logic               w_assign;

    // a commit on a slot not yet seen hands out the next index
    assign w_assign = i_req.commit && !r_hit;

    // valid bits and next index counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SEEN_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_next_dense <= '0;
        end else if (w_assign) begin
            r_valid[r_slot] <= 1'b1;
            r_next_dense    <= r_next_dense + DENSE_W'(1);
        end
    end

    // lookup registers the valid bit and the stored index
    always_ff @(posedge i_clk) begin
        if (i_req.lookup) begin
            r_hit      <= r_valid[i_req.slot];
            r_rd_dense <= r_mem[i_req.slot];
            r_slot     <= i_req.slot;
        end
    end

    // dense index memory write
    always_ff @(posedge i_clk) begin
        if (w_assign) begin
            r_mem[r_slot] <= r_next_dense;
        end
    end

    assign o_rsp.dense = r_hit ? r_rd_dense : r_next_dense;
    assign o_rsp.first = !r_hit;

endmodule

FILE: hw/rtl/nearest_palette_color_mapper.sv
// Nearest palette color mapper. A load transaction writes one RGBA palette slot and
// its result (the slot) is registered in the output register from the emit state, and
// no new transaction is taken before that. A pixel transaction walks the first
// min(entry_count, PALETTE_DEPTH, 256) slots through one shared squared-distance unit,
// one slot per cycle, keeping the lowest slot on ties. Its steps are the palette reads,
// the read register, the two distance stages and the drain check, then first-use
// lookup, commit and output. With an empty palette the pixel skips the search and maps
// to slot 256. A stalled output register adds its stall cycles before the result can
// be placed. The block takes one transaction at a time and holds o_stall high while it
// works; a finished result sits in the output register, so the next transaction may be
// taken while it waits. Pixels with alpha zero are matched as all channels zero.
// Depends on npcm_pkg, npcm_palette_ram, npcm_dist_unit and npcm_seen_table.
module nearest_palette_color_mapper #(
    parameter int unsigned PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  npcm_pkg::t_in_item   i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output npcm_pkg::t_out_item  o_data,
    input  logic                 i_stall,
    input  logic                 i_cfg_we,
    input  logic [8:0]           i_cfg_data
);
    import npcm_pkg::*;

    localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int unsigned SEARCH_MAX =
        (PALETTE_DEPTH < SEARCH_LIMIT) ? PALETTE_DEPTH : SEARCH_LIMIT;
    localparam logic [SLOT_W-1:0] SEARCH_MAX_W = SLOT_W'(SEARCH_MAX);

    t_state            r_state;
    t_state            n_state;
    logic [8:0]        r_entry_count;
    t_rgba             r_pixel;
    logic [SLOT_W-1:0] r_count;
    logic [SLOT_W-1:0] r_issue;
    logic [SLOT_W-1:0] r_chosen;
    logic [DIST_W-1:0] r_best;
    logic              r_best_valid;
    t_dist_tag         r_rd_tag;
    t_out_item         r_res;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic              w_accept;
    logic              w_issue;
    logic              w_emit;
    logic              w_last;
    logic              w_load_we;
    logic [SLOT_W-1:0] w_count;
    t_rgba             w_wdata;
    t_rgba             w_entry;
    t_dist_tag         w_tag;
    t_dist_out         w_dist;
    logic              w_dist_busy;
    t_seen_req         w_seen_req;
    t_seen_rsp         w_seen_rsp;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_data;
        end
    end

    // slots searched, saturated at the depth and at 256
    assign w_count  = (r_entry_count > SEARCH_MAX_W) ? SEARCH_MAX_W : r_entry_count;
    assign w_accept = i_valid && !o_stall;
    assign w_last   = (r_issue == r_count - SLOT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_data.op == OP_LOAD) begin
                        n_state = ST_EMIT;
                    end else if (w_count == '0) begin
                        n_state = ST_LOOKUP;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_tag.valid && !w_dist_busy && !w_dist.valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall           = (r_state != ST_IDLE);
        w_issue           = (r_state == ST_SEARCH);
        w_emit            = (r_state == ST_EMIT) && (!r_out_valid || !i_stall);
        w_seen_req.lookup = (r_state == ST_LOOKUP);
        w_seen_req.commit = (r_state == ST_COMMIT);
        w_seen_req.slot   = r_chosen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // palette load on an accepted load transaction inside the depth
    assign w_load_we     = w_accept && (i_data.op == OP_LOAD)
                           && (32'(i_data.entry_index) < PALETTE_DEPTH);
    assign w_wdata.red   = i_data.red;
    assign w_wdata.green = i_data.green;
    assign w_wdata.blue  = i_data.blue;
    assign w_wdata.alpha = i_data.alpha;

    npcm_palette_ram #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (AW'(i_data.entry_index)),
        .i_wdata (w_wdata),
        .i_raddr (AW'(r_issue)),
        .o_rdata (w_entry)
    );

    // pixel latch and search counter
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pixel.red   <= (i_data.alpha == '0) ? 8'd0 : i_data.red;
            r_pixel.green <= (i_data.alpha == '0) ? 8'd0 : i_data.green;
            r_pixel.blue  <= (i_data.alpha == '0) ? 8'd0 : i_data.blue;
            r_pixel.alpha <= i_data.alpha;
            r_count       <= w_count;
            r_issue       <= '0;
        end else if (w_issue) begin
            r_issue <= r_issue + SLOT_W'(1);
        end
    end

    // tag follows the registered palette read
    always_ff @(posedge i_clk) begin
        r_rd_tag.slot <= r_issue[7:0];
        if (!i_rst_n) begin
            r_rd_tag.valid <= 1'b0;
        end else begin
            r_rd_tag.valid <= w_issue;
        end
    end

    assign w_tag = r_rd_tag;

    npcm_dist_unit u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pixel  (r_pixel),
        .i_entry  (w_entry),
        .i_tag    (w_tag),
        .o_result (w_dist),
        .o_busy   (w_dist_busy)
    );

    // running minimum, strict compare keeps the lower slot on ties
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_best_valid <= 1'b0;
            r_chosen     <= DEFAULT_SLOT;
        end else if (w_dist.valid && (!r_best_valid || (w_dist.sq_dist < r_best))) begin
            r_best_valid <= 1'b1;
            r_best       <= w_dist.sq_dist;
            r_chosen     <= SLOT_W'(w_dist.slot);
        end
    end

    npcm_seen_table u_seen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_seen_req),
        .o_rsp   (w_seen_rsp)
    );

    // result holding register
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_data.op == OP_LOAD)) begin
            r_res.chosen_entry <= SLOT_W'(i_data.entry_index);
            r_res.dense_index  <= '0;
            r_res.first_use    <= 1'b0;
        end else if (w_seen_req.commit) begin
            r_res.chosen_entry <= r_chosen;
            r_res.dense_index  <= w_seen_rsp.dense;
            r_res.first_use    <= w_seen_rsp.first;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

FILE: tb/tb_nearest_palette_color_mapper.sv
// self-checking testbench for nearest_palette_color_mapper: directed table, then random phases
// typed rows are checked against the table, others against an in-bench predictor of palette
// search and first-use indexing; depends on npcm_pkg and the nearest_palette_color_mapper rtl
module tb_nearest_palette_color_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    import npcm_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    // one row of the directed table: either a register write or a transaction
    typedef struct {
        bit         is_cfg;
        logic [8:0] cfg_value;
        t_in_item   req;
        bit         typed;
        t_out_item  want;
    } t_stim_row;

    localparam t_in_item  NO_REQ    = '0;
    localparam t_out_item NO_RESULT = '0;
    localparam int        HOLD_CYCLES = 400;
    localparam int        DRAIN_CYCLES = 300;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    t_in_item   i_data     = '0;
    logic       o_stall;
    logic       o_valid;
    t_out_item  o_data;
    logic       i_stall    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [8:0] i_cfg_data = '0;

    // predictor state
    t_rgba      palette_rgba [256];
    bit         slot_loaded [256];
    bit         entry_seen [257];
    logic [8:0] entry_rank [257];
    logic [8:0] rank_next = '0;
    logic [8:0] entries_in_use = '0;

    t_out_item  expected_q [$];
    int         err_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_reqs = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    t_stim_row  directed_rows [22];

    nearest_palette_color_mapper dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #(30_000_000);
        $display("simulation failed");
        $finish;
    end

    // expected mapping of one transaction, updating palette and first-use state
    function automatic t_out_item predict_mapping(t_in_item req);
        t_out_item   res;
        t_rgba       px;
        int unsigned span;
        int unsigned best;
        int unsigned sq_dist;
        int          dr, dg, db, da;
        logic [8:0]  pick;
        res = '0;
        if (req.op == OP_LOAD) begin
            palette_rgba[req.entry_index] = {req.red, req.green, req.blue, req.alpha};
            slot_loaded[req.entry_index]  = 1'b1;
            res.chosen_entry = {1'b0, req.entry_index};
            return res;
        end
        px = {req.red, req.green, req.blue, req.alpha};
        // transparent pixels match as black with zero alpha
        if (req.alpha == 8'd0)
            px = '0;
        span = entries_in_use;
        if (span > PALETTE_DEPTH_DEF)
            span = PALETTE_DEPTH_DEF;
        if (span > SEARCH_LIMIT)
            span = SEARCH_LIMIT;
        pick = DEFAULT_SLOT;
        best = 32'hFFFF_FFFF;
        // strict compare keeps the lower slot on ties
        for (int s = 0; s < span; s++) begin
            dr = int'(px.red) - int'(palette_rgba[s].red);
            dg = int'(px.green) - int'(palette_rgba[s].green);
            db = int'(px.blue) - int'(palette_rgba[s].blue);
            da = int'(px.alpha) - int'(palette_rgba[s].alpha);
            sq_dist = dr * dr + dg * dg + db * db + da * da;
            if (sq_dist < best) begin
                best = sq_dist;
                pick = 9'(s);
            end
        end
        if (!entry_seen[pick]) begin
            entry_seen[pick] = 1'b1;
            entry_rank[pick] = rank_next;
            rank_next = rank_next + 9'd1;
            res.first_use = 1'b1;
        end
        res.chosen_entry = pick;
        res.dense_index  = entry_rank[pick];
        return res;
    endfunction

    // small saturating shift of one channel, for near misses
    function automatic logic [7:0] nudge(logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // random transaction; pixels partly aimed at the slots in use
    function automatic t_in_item random_request(int unsigned span);
        t_in_item    req;
        t_rgba       tone;
        int unsigned roll;
        roll = $urandom_range(99);
        req.op = OP_PIXEL;
        req.entry_index = 8'($urandom);
        {req.red, req.green, req.blue, req.alpha} = $urandom;
        if (roll < 25) begin
            req.op = OP_LOAD;
            if (span != 0 && $urandom_range(1) == 1)
                req.entry_index = 8'($urandom_range(span - 1));
            // duplicate entries make ties
            if (span != 0 && $urandom_range(3) == 0)
                {req.red, req.green, req.blue, req.alpha} = palette_rgba[$urandom_range(span - 1)];
        end else if (roll < 45 && span != 0) begin
            {req.red, req.green, req.blue, req.alpha} = palette_rgba[$urandom_range(span - 1)];
        end else if (roll < 60 && span != 0) begin
            tone = palette_rgba[$urandom_range(span - 1)];
            req.red   = nudge(tone.red);
            req.green = nudge(tone.green);
            req.blue  = nudge(tone.blue);
            req.alpha = nudge(tone.alpha);
        end else if (roll < 70) begin
            req.alpha = 8'd0;
        end else if (roll < 80) begin
            req.red   = {8{1'($urandom)}};
            req.green = {8{1'($urandom)}};
            req.blue  = {8{1'($urandom)}};
            req.alpha = {8{1'($urandom)}};
        end
        return req;
    endfunction

    // offer one transaction and record its expected result once taken
    task automatic send_request(input t_in_item req, input bit typed, input t_out_item want);
        t_out_item predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        predicted = predict_mapping(req);
        expected_q = {expected_q, (typed ? want : predicted)};
    endtask

    // stop offering and wait until every expected result has been taken
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    task automatic write_entry_count(input logic [8:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        entries_in_use = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct <= 0;
            end
            IDLE_SEND: begin
                send_idle_pct  = 74;
                recv_stall_pct <= 0;
            end
            IDLE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct <= 74;
            end
            default: begin
                send_idle_pct  = 6;
                recv_stall_pct <= 6;
            end
        endcase
    endtask

    // one random phase at a given palette size
    task automatic run_phase(input logic [8:0] count, input t_idle_mode mode,
                             input int unsigned items, input bit squeeze);
        t_in_item    req;
        int unsigned span;
        wait_for_results();
        set_idle_mode(mode);
        write_entry_count(count);
        span = (count > SEARCH_LIMIT) ? SEARCH_LIMIT : count;
        // load every slot the search will touch before any pixel
        for (int s = 0; s < span; s++) begin
            if (!slot_loaded[s]) begin
                req.op = OP_LOAD;
                req.entry_index = 8'(s);
                {req.red, req.green, req.blue, req.alpha} = $urandom;
                send_request(req, 1'b0, NO_RESULT);
            end
        end
        for (int unsigned k = 0; k < items; k++) begin
            if (squeeze && k == items / 4)
                hold_reqs <= hold_reqs + 1;
            if (k == items / 2)
                wait_for_results();
            send_request(random_request(span), 1'b0, NO_RESULT);
        end
    endtask

    // receiver stall, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result check; a transaction completes at the next rising edge
    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: chosen_entry %0d dense_index %0d",
                       o_data.chosen_entry, o_data.dense_index);
                err_count++;
            end else begin
                want = expected_q.pop_front();
                if (o_data.chosen_entry !== want.chosen_entry) begin
                    $error("chosen_entry expected %0d actual %0d",
                           want.chosen_entry, o_data.chosen_entry);
                    err_count++;
                end
                if (o_data.dense_index !== want.dense_index) begin
                    $error("dense_index expected %0d actual %0d",
                           want.dense_index, o_data.dense_index);
                    err_count++;
                end
                if (o_data.first_use !== want.first_use) begin
                    $error("first_use expected %0d actual %0d",
                           want.first_use, o_data.first_use);
                    err_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        directed_rows = '{
            // empty palette falls back to the default entry
            '{1'b0, 9'd0, '{OP_PIXEL, 8'h00, 8'h0a, 8'h14, 8'h1e, 8'h28}, 1'b1,
              '{DEFAULT_SLOT, 9'd0, 1'b1}},
            '{1'b0, 9'd0, '{OP_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00}, 1'b1,
              '{DEFAULT_SLOT, 9'd0, 1'b0}},
            // loads echo their slot
            '{1'b0, 9'd0, '{OP_LOAD, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{9'd0, 9'd0, 1'b0}},
            '{1'b0, 9'd0, '{OP_LOAD, 8'd1, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
              '{9'd1, 9'd0, 1'b0}},
            '{1'b0, 9'd0, '{OP_LOAD, 8'd2, 8'hff, 8'h00, 8'h00, 8'hff}, 1'b1,
              '{9'd2, 9'd0, 1'b0}},
            '{1'b0, 9'd0, '{OP_LOAD, 8'd3, 8'h00, 8'hff, 8'h00, 8'hff}, 1'b1,
              '{9'd3, 9'd0, 1'b0}},
            '{1'b0, 9'd0, '{OP_LOAD, 8'd4, 8'h00, 8'h00, 8'hff, 8'hff}, 1'b1,
              '{9'd4, 9'd0, 1'b0}},
            // same color as slot 2, for a tie
            '{1'b0, 9'd0, '{OP_LOAD, 8'd5, 8'hff, 8'h00, 8'h00, 8'hff}, 1'b1,
              '{9'd5, 9'd0, 1'b0}},
            '{1'b0, 9'd0, '{OP_LOAD, 8'd255, 8'h80, 8'h80, 8'h80, 8'h80}, 1'b1,
              '{9'd255, 9'd0, 1'b0}},
            '{1'b1, 9'd6, NO_REQ, 1'b0, NO_RESULT},
            // exact matches take the next dense index
            '{1'b0, 9'd0, '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{9'd0, 9'd1, 1'b1}},
            '{1'b0, 9'd0, '{OP_PIXEL, 8'haa, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
              '{9'd1, 9'd2, 1'b1}},
            '{1'b0, 9'd0, '{OP_PIXEL, 8'h00, 8'hfa, 8'h05, 8'h05, 8'hff}, 1'b0, NO_RESULT},
            // tie between slots 2 and 5
            '{1'b0, 9'd0, '{OP_PIXEL, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff}, 1'b0, NO_RESULT},
            // transparent pixel
            '{1'b0, 9'd0, '{OP_PIXEL, 8'h00, 8'hc8, 8'h64, 8'h32, 8'h00}, 1'b0, NO_RESULT},
            '{1'b0, 9'd0, '{OP_PIXEL, 8'h55, 8'h00, 8'h00, 8'hff, 8'hff}, 1'b0, NO_RESULT},
            '{1'b0, 9'd0, '{OP_PIXEL, 8'h00, 8'h00, 8'hff, 8'h00, 8'h80}, 1'b0, NO_RESULT},
            '{1'b1, 9'd1, NO_REQ, 1'b0, NO_RESULT},
            '{1'b0, 9'd0, '{OP_PIXEL, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, NO_RESULT},
            '{1'b1, 9'd0, NO_REQ, 1'b0, NO_RESULT},
            '{1'b0, 9'd0, '{OP_PIXEL, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04}, 1'b1,
              '{DEFAULT_SLOT, 9'd0, 1'b0}},
            '{1'b0, 9'd0, '{OP_LOAD, 8'd128, 8'h12, 8'h34, 8'h56, 8'h78}, 1'b1,
              '{9'd128, 9'd0, 1'b0}}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idle_mode(IDLE_NONE);

        // directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg) begin
                wait_for_results();
                write_entry_count(directed_rows[r].cfg_value);
            end else begin
                send_request(directed_rows[r].req, directed_rows[r].typed,
                             directed_rows[r].want);
            end
        end

        // random phases over palette sizes and idle patterns
        run_phase(9'd1,   IDLE_NONE, 150, 1'b0);
        run_phase(9'd16,  IDLE_SEND, 250, 1'b0);
        run_phase(9'd5,   IDLE_RECV, 250, 1'b1);
        run_phase(9'd37,  IDLE_BOTH, 200, 1'b0);
        run_phase(9'd256, IDLE_NONE, 150, 1'b1);
        run_phase(9'd511, IDLE_RECV, 80,  1'b0);
        run_phase(9'd0,   IDLE_SEND, 120, 1'b0);
        run_phase(9'd3,   IDLE_BOTH, 200, 1'b0);
        run_phase(9'd170, IDLE_NONE, 100, 1'b0);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
